// ----- hdl/assert_macros.svh -----
// ----------------------------------------------------------------------------
// assert_macros
// Assertion helpers used by the top-level RTL file.
// ----------------------------------------------------------------------------
`ifndef ASSERT_MACROS_SVH
`define ASSERT_MACROS_SVH

// Checked on every rising edge of i_clk, quiet while i_rst_n is low.
`define ASSERT_CLK(label, prop, msg) \
    label: assert property (@(posedge i_clk) disable iff (!i_rst_n) prop) else $error(msg);

// Checked on every rising edge, reset included.
`define ASSERT_ALWAYS(label, prop, msg) \
    label: assert property (@(posedge i_clk) prop) else $error(msg);

`endif

// ----- hdl/rspq_pkg.sv -----
// ----------------------------------------------------------------------------
// rspq_pkg
// Widths and pipeline depths shared by the sphere point pipeline.
// ----------------------------------------------------------------------------
package rspq_pkg;

    localparam int VW      = 30;          // magnitude / sum width
    localparam int NW      = 31;          // signed numerator width
    localparam int NSTEP   = 2 * VW;      // binary gcd steps
    localparam int FRONT   = 4;           // register, multiply, sum, check
    localparam int RED_LAT = 1 + NSTEP + VW + 1;
    localparam int TOT_LAT = FRONT + RED_LAT;
    localparam int DEN_W   = 15;
    localparam logic [2*DEN_W-1:0] PSQ_RST = 30'd1073676289;
    localparam logic [DEN_W-1:0]   DEN_RST = 15'd32767;

endpackage

// ----- hdl/rspq_reduce.sv -----
// ----------------------------------------------------------------------------
// rspq_reduce
// Pipelined reduction of mag/s to lowest terms: common-power-of-two strip,
// binary gcd steps, then restoring division of both terms by the odd gcd.
// ----------------------------------------------------------------------------
module rspq_reduce
    import rspq_pkg::*;
(
    input  logic          i_clk,
    input  logic          i_en,
    input  logic [VW-1:0] i_mag,
    input  logic          i_neg,
    input  logic [VW-1:0] i_s,
    output logic [NW-1:0] o_num,
    output logic [VW-1:0] o_den
);

    logic [VW-1:0] r_u  [0:NSTEP];
    logic [VW-1:0] r_v  [0:NSTEP];
    logic [VW-1:0] r_u0 [0:NSTEP];
    logic [VW-1:0] r_v0 [0:NSTEP];
    logic          r_sg [0:NSTEP];

    logic [VW-1:0] r_rn [1:VW];
    logic [VW-1:0] r_rd [1:VW];
    logic [VW-1:0] r_qn [1:VW];
    logic [VW-1:0] r_qd [1:VW];
    logic [VW-1:0] r_xn [1:VW];
    logic [VW-1:0] r_xd [1:VW];
    logic [VW-1:0] r_g  [1:VW];
    logic          r_ng [1:VW];

    logic [VW-1:0] w_or;
    logic [$clog2(VW)-1:0] w_k;
    logic [NW-1:0] r_num;
    logic [VW-1:0] r_den;

    // lowest set bit of mag|s; s is never zero for an item that passes the sum check
    assign w_or = i_mag | i_s;
    always_comb begin
        w_k = '0;
        for (int i = VW - 1; i >= 0; i--) begin
            if (w_or[i]) w_k = ($clog2(VW))'(i);
        end
    end

    always_ff @(posedge i_clk) begin
        if (i_en) begin
            r_u[0]  <= i_mag >> w_k;
            r_v[0]  <= i_s >> w_k;
            r_u0[0] <= i_mag >> w_k;
            r_v0[0] <= i_s >> w_k;
            r_sg[0] <= i_neg;
        end
    end

    genvar gi;
    generate
        for (gi = 0; gi < NSTEP; gi++) begin : g_step
            logic [VW-1:0] n_u, n_v;
            always_comb begin
                n_u = r_u[gi];
                n_v = r_v[gi];
                if (r_u[gi] == '0 || r_v[gi] == '0) begin
                    n_u = r_u[gi];
                end else if (!r_u[gi][0]) begin
                    n_u = r_u[gi] >> 1;
                end else if (!r_v[gi][0]) begin
                    n_v = r_v[gi] >> 1;
                end else if (r_u[gi] >= r_v[gi]) begin
                    n_u = (r_u[gi] - r_v[gi]) >> 1;
                end else begin
                    n_v = (r_v[gi] - r_u[gi]) >> 1;
                end
            end
            always_ff @(posedge i_clk) begin
                if (i_en) begin
                    r_u[gi+1]  <= n_u;
                    r_v[gi+1]  <= n_v;
                    r_u0[gi+1] <= r_u0[gi];
                    r_v0[gi+1] <= r_v0[gi];
                    r_sg[gi+1] <= r_sg[gi];
                end
            end
        end

        for (gi = 0; gi < VW; gi++) begin : g_div
            logic [VW-1:0] s_rn, s_rd, s_qn, s_qd, s_xn, s_xd, s_g;
            logic          s_ng;
            logic [VW:0]   t_rn, t_rd;
            if (gi == 0) begin : g_first
                assign s_rn = '0;
                assign s_rd = '0;
                assign s_qn = '0;
                assign s_qd = '0;
                assign s_xn = r_u0[NSTEP];
                assign s_xd = r_v0[NSTEP];
                assign s_g  = r_u[NSTEP] | r_v[NSTEP];
                assign s_ng = r_sg[NSTEP];
            end else begin : g_next
                assign s_rn = r_rn[gi];
                assign s_rd = r_rd[gi];
                assign s_qn = r_qn[gi];
                assign s_qd = r_qd[gi];
                assign s_xn = r_xn[gi];
                assign s_xd = r_xd[gi];
                assign s_g  = r_g[gi];
                assign s_ng = r_ng[gi];
            end
            assign t_rn = {s_rn, s_xn[VW-1]};
            assign t_rd = {s_rd, s_xd[VW-1]};
            always_ff @(posedge i_clk) begin
                if (i_en) begin
                    if (t_rn >= {1'b0, s_g}) begin
                        r_rn[gi+1] <= VW'(t_rn - {1'b0, s_g});
                        r_qn[gi+1] <= {s_qn[VW-2:0], 1'b1};
                    end else begin
                        r_rn[gi+1] <= t_rn[VW-1:0];
                        r_qn[gi+1] <= {s_qn[VW-2:0], 1'b0};
                    end
                    if (t_rd >= {1'b0, s_g}) begin
                        r_rd[gi+1] <= VW'(t_rd - {1'b0, s_g});
                        r_qd[gi+1] <= {s_qd[VW-2:0], 1'b1};
                    end else begin
                        r_rd[gi+1] <= t_rd[VW-1:0];
                        r_qd[gi+1] <= {s_qd[VW-2:0], 1'b0};
                    end
                    r_xn[gi+1] <= s_xn << 1;
                    r_xd[gi+1] <= s_xd << 1;
                    r_g[gi+1]  <= s_g;
                    r_ng[gi+1] <= s_ng;
                end
            end
        end
    endgenerate

    always_ff @(posedge i_clk) begin
        if (i_en) begin
            r_num <= r_ng[VW] ? (NW'(0) - {1'b0, r_qn[VW]}) : {1'b0, r_qn[VW]};
            r_den <= r_qd[VW];
        end
    end

    assign o_num = r_num;
    assign o_den = r_den;

endmodule

// ----- hdl/rational_sphere_point_from_quad_top.sv -----
// ----------------------------------------------------------------------------
// rational_sphere_point_from_quad_top
// Rational unit sphere point from four numerators over a common denominator.
// ----------------------------------------------------------------------------
// One item enters per cycle unless the output stalls, and passes four front
// stages (input register, eight 16x16 products, sums, range and sum check),
// then per coordinate a 60-step binary gcd pipeline and a 30-step restoring
// divider pair. Rejected items simply vanish from the pipe. The whole pipe
// advances together; it stalls only while a finished point waits on the
// output. Denominator writes take effect at once and belong to idle periods.
`include "assert_macros.svh"

module rational_sphere_point_from_quad_top
    import rspq_pkg::*;
#(
    parameter int COORD_BITS = 16
)
(
    input  logic                    i_clk,
    input  logic                    i_rst_n,
    input  logic                    i_cfg_valid,
    output logic                    o_cfg_ready,
    input  logic [DEN_W-1:0]        i_cfg_data,       // denominator
    input  logic                    i_s_axis_tvalid,
    output logic                    o_s_axis_tready,
    // coord_a, coord_b, coord_c, coord_d, zero fill
    input  logic [((4*COORD_BITS+7)/8)*8-1:0] i_s_axis_tdata,
    output logic                    o_m_axis_tvalid,
    input  logic                    i_m_axis_tready,
    // x_num, x_den, y_num, y_den, z_num, z_den, zero fill
    output logic [((3*(NW+VW)+7)/8)*8-1:0]    o_m_axis_tdata
);

    localparam int CW    = (COORD_BITS > 16 ? COORD_BITS : 16) + 2;
    localparam int OUT_W = ((3*(NW+VW)+7)/8)*8;

    logic [DEN_W-1:0]   r_den;
    logic [2*DEN_W-1:0] r_psq;
    logic [TOT_LAT-1:0] r_vld;
    logic               w_en;

    logic signed [15:0] r_a  [0:3];
    logic               r_inr1;
    logic signed [31:0] r_sq [0:3];
    logic signed [31:0] r_p13, r_p02, r_p23, r_p01;
    logic               r_inr2;
    logic signed [33:0] r_s, r_xn, r_yn, r_zn;
    logic               r_inr3;
    logic [VW-1:0]      r_s4, r_mx, r_my, r_mz;
    logic               r_nx, r_ny, r_nz;

    logic signed [CW-1:0] w_p;
    logic [3:0]           w_ok;
    logic                 w_chk;
    logic [NW-1:0] w_xn, w_yn, w_zn;
    logic [VW-1:0] w_xd, w_yd, w_zd;

    assign w_en            = !o_m_axis_tvalid || i_m_axis_tready;
    assign o_s_axis_tready = i_rst_n && w_en;
    assign o_cfg_ready     = i_rst_n;
    assign o_m_axis_tvalid = r_vld[TOT_LAT-1];

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_den <= DEN_RST;
            r_psq <= PSQ_RST;
        end else if (i_cfg_valid) begin
            r_den <= i_cfg_data;
            r_psq <= i_cfg_data * i_cfg_data;
        end
    end

    // range check: -p <= a <= p-1
    assign w_p = $signed({{(CW-DEN_W){1'b0}}, r_den});
    genvar gi;
    generate
        for (gi = 0; gi < 4; gi++) begin : g_in
            logic signed [CW-1:0] w_a;
            assign w_a = CW'($signed(i_s_axis_tdata[gi*COORD_BITS +: COORD_BITS]));
            assign w_ok[gi] = (w_a >= -w_p) && (w_a <= w_p - CW'(1));
            always_ff @(posedge i_clk) begin
                if (w_en) r_a[gi] <= w_a[15:0];
            end
        end
    endgenerate

    assign w_chk = r_inr3 && (r_s != '0) && (r_s < $signed({4'b0, r_psq}));

    always_ff @(posedge i_clk) begin
        if (w_en) begin
            r_inr1 <= &w_ok;
            for (int i = 0; i < 4; i++) begin
                r_sq[i] <= r_a[i] * r_a[i];
            end
            r_p13  <= r_a[1] * r_a[3];
            r_p02  <= r_a[0] * r_a[2];
            r_p23  <= r_a[2] * r_a[3];
            r_p01  <= r_a[0] * r_a[1];
            r_inr2 <= r_inr1;
            r_s    <= 34'(r_sq[0]) + 34'(r_sq[1]) + 34'(r_sq[2]) + 34'(r_sq[3]);
            r_xn   <= (34'(r_p13) + 34'(r_p02)) <<< 1;
            r_yn   <= (34'(r_p23) - 34'(r_p01)) <<< 1;
            r_zn   <= 34'(r_sq[0]) + 34'(r_sq[3]) - 34'(r_sq[1]) - 34'(r_sq[2]);
            r_inr3 <= r_inr2;
            r_s4   <= r_s[VW-1:0];
            r_nx   <= r_xn[33];
            r_ny   <= r_yn[33];
            r_nz   <= r_zn[33];
            r_mx   <= r_xn[33] ? VW'(-r_xn) : r_xn[VW-1:0];
            r_my   <= r_yn[33] ? VW'(-r_yn) : r_yn[VW-1:0];
            r_mz   <= r_zn[33] ? VW'(-r_zn) : r_zn[VW-1:0];
        end
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_vld <= '0;
        end else if (w_en) begin
            r_vld[0] <= i_s_axis_tvalid;
            r_vld[1] <= r_vld[0];
            r_vld[2] <= r_vld[1];
            r_vld[3] <= r_vld[2] && w_chk;
            r_vld[TOT_LAT-1:FRONT] <= r_vld[TOT_LAT-2:FRONT-1];
        end
    end

    rspq_reduce u_red_x (
        .i_clk (i_clk), .i_en (w_en), .i_mag (r_mx), .i_neg (r_nx), .i_s (r_s4),
        .o_num (w_xn), .o_den (w_xd)
    );
    rspq_reduce u_red_y (
        .i_clk (i_clk), .i_en (w_en), .i_mag (r_my), .i_neg (r_ny), .i_s (r_s4),
        .o_num (w_yn), .o_den (w_yd)
    );
    rspq_reduce u_red_z (
        .i_clk (i_clk), .i_en (w_en), .i_mag (r_mz), .i_neg (r_nz), .i_s (r_s4),
        .o_num (w_zn), .o_den (w_zd)
    );

    assign o_m_axis_tdata = OUT_W'({w_zd, w_zn, w_yd, w_yn, w_xd, w_xn});

    `ASSERT_CLK(a_stall_blocks_in, (o_m_axis_tvalid && !i_m_axis_tready) |-> !o_s_axis_tready, "input taken while output stalled")
    `ASSERT_CLK(a_accept_enters, (i_s_axis_tvalid && o_s_axis_tready) |=> r_vld[0], "accepted beat not in pipe")
    `ASSERT_CLK(a_den_nonzero, o_m_axis_tvalid |-> (w_xd != '0 && w_yd != '0 && w_zd != '0), "zero denominator on output")

endmodule

// ----- tb/tb_rational_sphere_point_from_quad_top.sv -----
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// tb_rational_sphere_point_from_quad_top
// Drives quaternion numerators under several denominators, predicts each
// reduced sphere point and checks the output stream beat by beat, with
// bursty input and a stalling output.
// ----------------------------------------------------------------------------
module tb_rational_sphere_point_from_quad_top;
    import rspq_pkg::*;

    localparam int CB    = 16;
    localparam int IN_W  = ((4*CB+7)/8)*8;
    localparam int OUT_W = ((3*(NW+VW)+7)/8)*8;

    typedef struct packed {
        logic [VW-1:0] z_den;
        logic [NW-1:0] z_num;
        logic [VW-1:0] y_den;
        logic [NW-1:0] y_num;
        logic [VW-1:0] x_den;
        logic [NW-1:0] x_num;
    } t_point;

    typedef struct {
        logic [CB-1:0] a, b, c, d;
        bit            typed;   // expected point written into the row
        bit            hit;     // a point is expected
        t_point        pt;
    } t_row;

    logic              i_clk = 0;
    logic              i_rst_n = 0;
    logic              i_cfg_valid = 0;
    logic [DEN_W-1:0]  i_cfg_data = '0;
    logic              i_s_axis_tvalid = 0;
    logic [IN_W-1:0]   i_s_axis_tdata = '0;
    logic              i_m_axis_tready = 0;
    logic              o_cfg_ready, o_s_axis_tready, o_m_axis_tvalid;
    logic [OUT_W-1:0]  o_m_axis_tdata;

    rational_sphere_point_from_quad_top #(.COORD_BITS(CB)) uut (.*);

    always begin
        #5 i_clk = 1;
        #5 i_clk = 0;
    end

    logic [DEN_W-1:0] denom;
    t_point           pending_points[$];
    int               errors = 0;
    bit               stall_en = 1;

    function automatic longint gcd64(longint u, longint v);
        longint t;
        while (v != 0) begin
            t = u % v;
            u = v;
            v = t;
        end
        return u;
    endfunction

    function automatic void reduce_frac(longint n, longint s,
                                        output logic [NW-1:0] rn,
                                        output logic [VW-1:0] rd);
        longint mag, g;
        mag = (n < 0) ? -n : n;
        g = gcd64(mag, s);
        rn = NW'((n < 0) ? -(mag / g) : (mag / g));
        rd = VW'(s / g);
    endfunction

    function automatic bit sphere_point(logic [CB-1:0] ra, logic [CB-1:0] rb,
                                        logic [CB-1:0] rc, logic [CB-1:0] rd,
                                        output t_point pt);
        longint a0, a1, a2, a3, p, s;
        a0 = longint'($signed(ra));
        a1 = longint'($signed(rb));
        a2 = longint'($signed(rc));
        a3 = longint'($signed(rd));
        p  = longint'(denom);
        pt = '0;
        if (a0 < -p || a0 > p-1 || a1 < -p || a1 > p-1 ||
            a2 < -p || a2 > p-1 || a3 < -p || a3 > p-1) return 0;
        s = a0*a0 + a1*a1 + a2*a2 + a3*a3;
        if (s == 0 || s >= p*p) return 0;
        reduce_frac(2*(a1*a3 + a0*a2), s, pt.x_num, pt.x_den);
        reduce_frac(2*(a2*a3 - a0*a1), s, pt.y_num, pt.y_den);
        reduce_frac(a0*a0 + a3*a3 - a1*a1 - a2*a2, s, pt.z_num, pt.z_den);
        return 1;
    endfunction

    // output side: random stalls, compare against oldest prediction
    always @(posedge i_clk) begin
        t_point got, want;
        if (i_rst_n && o_m_axis_tvalid && i_m_axis_tready) begin
            got = t_point'(o_m_axis_tdata[3*(NW+VW)-1:0]);
            if (pending_points.size() == 0) begin
                errors++;
                if (errors <= 10) $display("ERROR: unexpected point %h", got);
            end else begin
                want = pending_points.pop_front();
                if (got !== want || o_m_axis_tdata[OUT_W-1:3*(NW+VW)] !== '0) begin
                    errors++;
                    if (errors <= 10)
                        $display("ERROR: x %0d/%0d y %0d/%0d z %0d/%0d, got x %0d/%0d y %0d/%0d z %0d/%0d",
                            $signed(want.x_num), want.x_den, $signed(want.y_num), want.y_den,
                            $signed(want.z_num), want.z_den, $signed(got.x_num), got.x_den,
                            $signed(got.y_num), got.y_den, $signed(got.z_num), got.z_den);
                end
            end
        end
        i_m_axis_tready <= !stall_en || ($urandom_range(0, 3) != 0);
        if ($urandom_range(0, 199) == 0) stall_en <= !stall_en;
    end

    task automatic send_quad(t_row r);
        t_point pt;
        bit     hit;
        int     gap;
        if ($urandom_range(0, 5) == 0) begin
            gap = $urandom_range(1, 12);
            i_s_axis_tvalid <= 0;
            repeat (gap) @(posedge i_clk);
        end
        i_s_axis_tvalid <= 1;
        i_s_axis_tdata  <= {r.d, r.c, r.b, r.a};
        do @(posedge i_clk); while (!o_s_axis_tready);
        hit = sphere_point(r.a, r.b, r.c, r.d, pt);
        if (r.typed && (hit != r.hit || (hit && pt != r.pt))) begin
            errors++;
            if (errors <= 10) $display("ERROR: table row disagrees with prediction");
        end
        if (hit) pending_points.push_back(pt);
    endtask

    task automatic drain_pipe();
        i_s_axis_tvalid <= 0;
        while (pending_points.size() != 0) @(posedge i_clk);
        repeat (TOT_LAT + 20) @(posedge i_clk);
    endtask

    task automatic write_denom(logic [DEN_W-1:0] v);
        i_cfg_valid <= 1;
        i_cfg_data  <= v;
        do @(posedge i_clk); while (!o_cfg_ready);
        i_cfg_valid <= 0;
        denom = v;
    endtask

    function automatic logic [CB-1:0] rand_coord(int p);
        int k;
        k = $urandom_range(0, 9);
        if (k == 0) return CB'($urandom);
        if (k == 1) return CB'(p - 1);
        if (k == 2) return CB'(-p);
        return CB'($urandom_range(0, 2*p - 1) - p);
    endfunction

    localparam t_point PT_Z1 = '{z_den: 1, z_num: 1, y_den: 1, y_num: 0,
                                 x_den: 1, x_num: 0};
    localparam t_point PT_ZM = '{z_den: 1, z_num: -31'sd1, y_den: 1, y_num: 0,
                                 x_den: 1, x_num: 0};
    localparam t_point PT_X  = '{z_den: 1, z_num: -31'sd1, y_den: 1, y_num: 0,
                                 x_den: 1, x_num: 0};

    t_row directed[] = '{
        '{16'd0, 16'd0, 16'd0, 16'd0, 1, 0, '0},           // zero sum
        '{16'd1, 16'd0, 16'd0, 16'd0, 1, 1, PT_Z1},
        '{16'hffff, 16'd0, 16'd0, 16'd0, 1, 1, PT_Z1},
        '{16'd0, 16'd1, 16'd0, 16'd0, 1, 1, PT_ZM},
        '{16'd0, 16'd0, 16'd1, 16'd0, 1, 1, PT_X},
        '{16'd0, 16'd0, 16'd0, 16'd1, 1, 1, PT_Z1},
        '{16'h7fff, 16'd0, 16'd0, 16'd0, 1, 0, '0},        // out of range
        '{16'h8001, 16'd0, 16'd0, 16'd0, 1, 0, '0},        // sum too large
        '{16'h8000, 16'd0, 16'd0, 16'd0, 1, 0, '0},        // out of range
        '{16'h7ffe, 16'd0, 16'd0, 16'd0, 1, 1, PT_Z1},
        '{16'd0, 16'h8002, 16'd0, 16'd0, 1, 1, PT_ZM},
        '{16'h7ffe, 16'd256, 16'd0, 16'd0, 1, 0, '0},      // sum too large
        '{16'd1, 16'd2, 16'd3, 16'd4, 0, 0, '0},
        '{16'hfffd, 16'd5, 16'hfff9, 16'd11, 0, 0, '0},
        '{16'd1000, 16'hfc18, 16'd1000, 16'hfc18, 0, 0, '0},
        '{16'h4000, 16'h4000, 16'hc000, 16'hc000, 0, 0, '0},
        '{16'h5555, 16'haaaa, 16'h1234, 16'hedcb, 0, 0, '0}
    };

    initial begin
        int dens[6];
        int ph, n, p;
        t_row r;
        dens = '{32767, 1, 2, 100, 7, 32767};
        denom = DEN_RST;
        repeat (3) @(posedge i_clk);
        i_rst_n <= 1;
        @(posedge i_clk);
        foreach (directed[i]) send_quad(directed[i]);
        drain_pipe();
        for (ph = 0; ph < 6; ph++) begin
            write_denom(DEN_W'(dens[ph]));
            p = dens[ph];
            r.typed = 0;
            for (n = 0; n < 200; n++) begin
                r.a = rand_coord(p);
                r.b = rand_coord(p);
                r.c = rand_coord(p);
                r.d = rand_coord(p);
                // keep the sum below p squared most of the time
                if (p > 2 && $urandom_range(0, 3) != 0) begin
                    r.a = CB'($signed(r.a) / 2);
                    r.b = CB'($signed(r.b) / 2);
                    r.c = CB'($signed(r.c) / 2);
                    r.d = CB'($signed(r.d) / 2);
                end
                send_quad(r);
                if (n == 100) drain_pipe();
            end
            drain_pipe();
        end
        write_denom('0);   // empty range: nothing passes
        for (n = 0; n < 20; n++) begin
            r.a = CB'($urandom_range(0, 3));
            r.b = '0; r.c = '0; r.d = '0;
            send_quad(r);
        end
        drain_pipe();
        if (errors == 0) begin
            $display("Test completed successfully");
        end else begin
            $display("Test completed with failures");
        end
        $finish;
    end

    initial begin
        #5ms;
        $display("Test completed with failures");
        $finish;
    end
endmodule
